### hdl/wlmd_pkg.sv
// ----------------------------------------------------------------------------
// wlmd_pkg
// Shared widths and types of the window local maxima detector.
// ----------------------------------------------------------------------------
`default_nettype none

package wlmd_pkg;

  localparam int GAIN_W   = 32;
  localparam int POS_W    = 32;
  localparam int RADIUS_W = 5;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain;
    logic [POS_W-1:0]         pos;
    logic                     cand;
  } wlmd_item_t;

  typedef struct packed {
    logic shift;
    logic win;
  } wlmd_ctl_t;

endpackage

`default_nettype wire

### hdl/wlmd_cell.sv
// ----------------------------------------------------------------------------
// wlmd_cell
// One pending element of the window: compares its gain with the newest gain
// and hands its element, with the updated candidate flag, to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module wlmd_cell (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire wlmd_pkg::wlmd_ctl_t              ctl,
  input  wire logic signed [wlmd_pkg::GAIN_W-1:0] g,
  input  wire wlmd_pkg::wlmd_item_t             left,
  output wlmd_pkg::wlmd_item_t                  cur,
  output wlmd_pkg::wlmd_item_t                  fwd,
  output logic                                  ge
);

  logic signed [wlmd_pkg::GAIN_W-1:0] gain;
  logic [wlmd_pkg::POS_W-1:0]         pos;
  logic                               cand;

  always_ff @(posedge clk) begin
    if (rst) begin
      cand <= 1'b0;
    end else if (ctl.shift) begin
      cand <= left.cand;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      gain <= left.gain;
      pos  <= left.pos;
    end
  end

  always_comb begin
    cur.gain = gain;
    cur.pos  = pos;
    cur.cand = cand;
    fwd.gain = gain;
    fwd.pos  = pos;
    fwd.cand = cand && !(ctl.win && (g > gain));
    ge       = ctl.win && (gain >= g);
  end

endmodule

`default_nettype wire

### hdl/window_local_maxima_detector.sv
// ----------------------------------------------------------------------------
// window_local_maxima_detector
// Reports the positions of a run of gains that are local maxima within a
// configurable radius, leftmost on a plateau, flushed at the end of a run.
// ----------------------------------------------------------------------------
//  Channel  Handshake             Payload
//  in       in_valid / in_stall   gain, position, last_item
//  out      out_valid / out_stall peak_position, peak_valid, end_of_run
//  cfg      cfg_write             cfg_data (window radius)
//
// An item enters the cell chain, then each element retired from the oldest
// cell passes through the output mux, one per step and possibly none, plus a
// step for a bare end mark; a new item waits until this drain is done.
// Reset clears the element count and candidate flags and sets the radius to 1.
// A stalled output holds the retire step; input is stalled while retiring.
// ----------------------------------------------------------------------------
`default_nettype none

module window_local_maxima_detector #(
  parameter int MAX_RADIUS = 31
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [wlmd_pkg::RADIUS_W-1:0]      cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [wlmd_pkg::GAIN_W-1:0] gain,
  input  wire logic [wlmd_pkg::POS_W-1:0]         position,
  input  wire logic                               last_item,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [wlmd_pkg::POS_W-1:0]              peak_position,
  output logic                                    peak_valid,
  output logic                                    end_of_run
);

  localparam int NCELL = MAX_RADIUS + 1;
  localparam int IW    = $clog2(NCELL);
  localparam int CW    = $clog2(NCELL + 1);

  typedef enum logic {ST_IDLE, ST_DRAIN} state_t;

  state_t                         state;
  logic [wlmd_pkg::RADIUS_W-1:0]  radius;
  logic [CW-1:0]                  count;
  logic                           last_flag;
  logic                           emitted;

  logic [CW-1:0]                  r_eff;
  logic [CW-1:0]                  keep;
  logic [CW-1:0]                  idx;
  logic                           accept;
  logic                           out_free;
  logic                           new_cand;
  logic                           any_below;
  logic                           sel_cand;
  logic [wlmd_pkg::POS_W-1:0]     sel_pos;

  wlmd_pkg::wlmd_item_t           link [NCELL];
  wlmd_pkg::wlmd_item_t           cur  [NCELL];
  wlmd_pkg::wlmd_ctl_t            ctl  [NCELL];
  logic [NCELL-1:0]               ge_vec;
  logic [NCELL-1:0]               cand_vec;
  logic [NCELL-1:0]               below_vec;

  assign in_stall = (state == ST_DRAIN);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    if (int'(radius) > MAX_RADIUS) begin
      r_eff = CW'(MAX_RADIUS);
    end else begin
      r_eff = CW'(radius);
    end
  end

  assign keep     = last_flag ? '0 : r_eff;
  assign idx      = count - CW'(1);
  assign new_cand = !(|ge_vec);

  assign link[0].gain = gain;
  assign link[0].pos  = position;
  assign link[0].cand = new_cand;

  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    assign ctl[j].shift = accept;
    assign ctl[j].win   = (CW'(j) < count) && (CW'(j) < r_eff);
    assign cand_vec[j]  = cur[j].cand;
    assign below_vec[j] = cur[j].cand && (CW'(j) < idx);

    if (j < NCELL - 1) begin : g_link
      wlmd_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .ctl  (ctl[j]),
        .g    (gain),
        .left (link[j]),
        .cur  (cur[j]),
        .fwd  (link[j+1]),
        .ge   (ge_vec[j])
      );
    end else begin : g_tail
      wlmd_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .ctl  (ctl[j]),
        .g    (gain),
        .left (link[j]),
        .cur  (cur[j]),
        .fwd  (),
        .ge   (ge_vec[j])
      );
    end
  end

  assign any_below = |below_vec;
  assign sel_cand  = cand_vec[idx[IW-1:0]];
  assign sel_pos   = cur[idx[IW-1:0]].pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= wlmd_pkg::RADIUS_W'(1);
    end else if (cfg_write) begin
      radius <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      last_flag <= 1'b0;
      emitted   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (out_free) begin
            out_valid <= 1'b0;
          end
          if (accept) begin
            count     <= count + CW'(1);
            last_flag <= last_item;
            emitted   <= 1'b0;
            state     <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (out_free) begin
            if (count > keep) begin
              out_valid <= sel_cand;
              if (sel_cand) begin
                peak_position <= sel_pos;
                peak_valid    <= 1'b1;
                end_of_run    <= last_flag && !any_below;
                emitted       <= 1'b1;
              end
              count <= idx;
              if ((idx <= keep) && !(last_flag && !emitted && !sel_cand)) begin
                state <= ST_IDLE;
              end
            end else begin
              out_valid <= last_flag && !emitted;
              if (last_flag && !emitted) begin
                peak_position <= '0;
                peak_valid    <= 1'b0;
                end_of_run    <= 1'b1;
              end
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          out_valid <= 1'b0;
          state     <= ST_IDLE;
        end
      endcase
    end
  end

  a_bare_mark_ends_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !peak_valid) |-> end_of_run)
    else $error("bare end mark without end of run");

  a_idle_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (int'(count) <= MAX_RADIUS))
    else $error("pending element count exceeds the window");

  a_accept_appends: assert property (@(posedge clk) disable iff (rst)
    accept |=> (count == $past(count) + CW'(1)))
    else $error("accepted item not appended to the chain");

  a_drain_after_last: assert property (@(posedge clk) disable iff (rst)
    (accept && last_item) |=> (state == ST_DRAIN && last_flag))
    else $error("last item did not start a flush");

endmodule

`default_nettype wire
